// ===== src/lrp_pkg.sv =====
`timescale 1ns / 1ps

package lrp_pkg;

   localparam int OP_W = 1;
   localparam int SLOT_W = 8;
   localparam int VALUE_W = 32;
   localparam int PROD_W = 2 * VALUE_W;
   localparam int FRAC_W = 16;
   localparam int SUM_W = 48;
   localparam int PROB_W = 16;
   localparam int FCOUNT_W = 9;
   localparam int SCOUNT_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int CNT_W = 13;
   localparam int Z_SPAN_W = 20;

   localparam int DEFAULT_MAX_FEATURES = 256;
   localparam int DEFAULT_SIGMOID_TABLE_BITS = 10;

   localparam logic [OP_W-1:0] OP_WEIGHT = 1'b0;
   localparam logic [OP_W-1:0] OP_FEATURE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIAS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FEATURE_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = 2'd2;

   typedef struct packed {
      logic first;
      logic done;
      logic last_sample;
   } tag_type;

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // e^x by Taylor series in Q32, then sigmoid in Q0.16 with rounding
   function automatic logic [PROB_W-1:0] sigmoid_entry(input int idx, input int tb);
      int k;
      int n;
      int fb;
      logic [63:0] m;
      logic [63:0] term;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] q;
      fb = tb - 4;
      k = idx - (1 << (tb - 1));
      m = 64'((k < 0) ? -k : k);
      term = 64'd1 << 32;
      e = term;
      for (n = 1; n < 200 && term != 64'd0; n++) begin
         term = udiv64(term * m, 64'(n) << fb);
         e = e + term;
      end
      den = (64'd1 << 32) + e;
      num = (k >= 0) ? e : (64'd1 << 32);
      q = udiv64((num << 16) + (den >> 1), den);
      return (q > 64'd65535) ? 16'hFFFF : q[PROB_W-1:0];
   endfunction

endpackage

// ===== src/lrp_weight_store.sv =====
`timescale 1ns / 1ps

module lrp_weight_store #(
   parameter int DEPTH = lrp_pkg::DEFAULT_MAX_FEATURES,
   parameter int ADDR_W = 8
) (
   input  logic                               clock,
   input  logic                               write_en,
   input  logic [ADDR_W-1:0]                  write_addr,
   input  logic signed [lrp_pkg::VALUE_W-1:0] write_data,
   input  logic                               read_en,
   input  logic [ADDR_W-1:0]                  read_addr,
   output logic signed [lrp_pkg::VALUE_W-1:0] read_data
);
   import lrp_pkg::*;

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

// ===== src/lrp_mac.sv =====
`timescale 1ns / 1ps

module lrp_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic signed [lrp_pkg::VALUE_W-1:0] value,
   input  lrp_pkg::tag_type                   tag,
   input  logic signed [lrp_pkg::VALUE_W-1:0] weight,
   input  logic signed [lrp_pkg::VALUE_W-1:0] bias,
   output logic                               head_ready,
   input  logic                               down_ready,
   output logic                               out_valid,
   output logic                               out_last_sample,
   output logic signed [lrp_pkg::SUM_W-1:0]   out_sum
);
   import lrp_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   logic                      a_valid_ff, a_valid_in;
   logic signed [VALUE_W-1:0] a_value_ff;
   tag_type                   a_tag_ff;

   logic                      b_valid_ff, b_valid_in;
   logic signed [PROD_W-1:0]  b_product_ff;
   tag_type                   b_tag_ff;

   logic                      c_valid_ff, c_valid_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   tag_type                   c_tag_ff;

   logic                      a_ready, b_ready, c_ready;
   logic                      b_load, c_load;
   logic signed [SUM_W-1:0]   start;
   logic signed [PROD_W-1:0]  shifted;
   logic signed [SUM_W:0]     sum_wide;

   assign c_ready = !c_valid_ff || !c_tag_ff.done || down_ready;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign head_ready = a_ready;

   assign b_load = a_valid_ff && b_ready;
   assign c_load = b_valid_ff && c_ready;

   assign a_valid_in = load || (a_valid_ff && !b_ready);
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   always_comb begin
      start = b_tag_ff.first ? {{(SUM_W-VALUE_W){bias[VALUE_W-1]}}, bias} : sum_ff;
      shifted = b_product_ff >>> FRAC_W;
      sum_wide = {start[SUM_W-1], start} + shifted[SUM_W:0];
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_value_ff <= value;
         a_tag_ff <= tag;
      end
      if (b_load) begin
         b_product_ff <= a_value_ff * weight;
         b_tag_ff <= a_tag_ff;
      end
      if (c_load) begin
         sum_ff <= sum_in;
         c_tag_ff <= b_tag_ff;
      end
   end

   assign out_valid = c_valid_ff && c_tag_ff.done;
   assign out_last_sample = c_tag_ff.last_sample;
   assign out_sum = sum_ff;

endmodule

// ===== src/lrp_sigmoid.sv =====
`timescale 1ns / 1ps

module lrp_sigmoid #(
   parameter int TABLE_BITS = lrp_pkg::DEFAULT_SIGMOID_TABLE_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic                             in_last_sample,
   input  logic signed [lrp_pkg::SUM_W-1:0] in_sum,
   output logic                             in_ready,
   output logic                             out_valid,
   input  logic                             out_stall,
   output logic [lrp_pkg::PROB_W-1:0]       out_probability,
   output logic                             out_last_sample
);
   import lrp_pkg::*;

   localparam int TABLE_SIZE = 1 << TABLE_BITS;
   localparam logic signed [SUM_W-1:0] Z_POS = SUM_W'(1) << (Z_SPAN_W - 1);
   localparam logic signed [SUM_W-1:0] Z_NEG = -Z_POS;

   logic [PROB_W-1:0] rom_w [TABLE_SIZE];

   genvar g;
   generate
      for (g = 0; g < TABLE_SIZE; g++) begin : g_rom
         localparam logic [PROB_W-1:0] ENTRY = sigmoid_entry(g, TABLE_BITS);
         assign rom_w[g] = ENTRY;
      end
   endgenerate

   logic                  d_valid_ff, d_valid_in;
   logic [TABLE_BITS-1:0] index_ff, index_in;
   logic                  d_last_ff;
   logic                  e_valid_ff, e_valid_in;
   logic [PROB_W-1:0]     prob_ff;
   logic                  e_last_ff;
   logic                  d_ready, e_ready;
   logic [SUM_W-1:0]      offset;

   assign e_ready = !e_valid_ff || !out_stall;
   assign d_ready = !d_valid_ff || e_ready;
   assign in_ready = d_ready;

   assign d_valid_in = d_ready ? in_valid : d_valid_ff;
   assign e_valid_in = e_ready ? d_valid_ff : e_valid_ff;

   always_comb begin
      offset = in_sum + Z_POS;
      if (in_sum < Z_NEG) begin
         index_in = '0;
      end else if (in_sum >= Z_POS) begin
         index_in = '1;
      end else begin
         index_in = offset[Z_SPAN_W-1 -: TABLE_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && d_ready) begin
         index_ff <= index_in;
         d_last_ff <= in_last_sample;
      end
      if (d_valid_ff && e_ready) begin
         prob_ff <= rom_w[index_ff];
         e_last_ff <= d_last_ff;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_probability = prob_ff;
   assign out_last_sample = e_last_ff;

endmodule

// ===== src/logistic_regression_predict_unit.sv =====
`timescale 1ns / 1ps
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_op, req_weight_slot, req_value
//  rsp      out        rsp_valid/stall    rsp_probability, rsp_last_sample
//  csr      in         csr_we             csr_index, csr_wdata
//
//  One transaction per cycle on req while req_stall is low. A sample's last feature passes
//  weight read, multiply, accumulate, table index and table read before it shows on rsp.
//  The accumulate stage holds the running sum; it takes one feature per cycle while no finished sum waits downstream.
//  Reset clears counters and valid flags; weights stay undefined until written.
//  rsp_stall backs up only stages that hold a result; req_stall rises when they are full.

module logistic_regression_predict_unit #(
   parameter int MAX_FEATURES = lrp_pkg::DEFAULT_MAX_FEATURES,
   parameter int SIGMOID_TABLE_BITS = lrp_pkg::DEFAULT_SIGMOID_TABLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [lrp_pkg::OP_W-1:0]             req_op,
   input  logic [lrp_pkg::SLOT_W-1:0]           req_weight_slot,
   input  logic signed [lrp_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [lrp_pkg::PROB_W-1:0]           rsp_probability,
   output logic                                 rsp_last_sample,
   input  logic                                 csr_we,
   input  logic [lrp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lrp_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lrp_pkg::*;

   localparam int PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

   logic signed [VALUE_W-1:0] bias_ff;
   logic [FCOUNT_W-1:0]       fcount_ff;
   logic [SCOUNT_W-1:0]       scount_ff;
   logic [PW-1:0]             feat_pos_ff, feat_pos_in;
   logic [SCOUNT_W-1:0]       sample_pos_ff, sample_pos_in;

   logic [CNT_W-1:0]          fc_eff;
   logic [PW-1:0]             pos_cl;
   logic                      feat_last;
   logic [SCOUNT_W:0]         sc_eff;
   logic                      sample_last;
   logic                      accept, accept_feat, accept_weight, slot_ok;
   tag_type                   tag_in;
   logic signed [VALUE_W-1:0] weight;
   logic                      head_ready;
   logic                      mac_valid, mac_last_sample, sig_ready;
   logic signed [SUM_W-1:0]   mac_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
         fcount_ff <= FCOUNT_W'(1);
         scount_ff <= SCOUNT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIAS: bias_ff <= csr_wdata[VALUE_W-1:0];
            CSR_FEATURE_COUNT: fcount_ff <= csr_wdata[FCOUNT_W-1:0];
            CSR_SAMPLE_COUNT: scount_ff <= csr_wdata[SCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept = req_valid && !req_stall;
   assign accept_feat = accept && (req_op == OP_FEATURE);
   assign accept_weight = accept && (req_op == OP_WEIGHT);
   assign slot_ok = CNT_W'(req_weight_slot) < CNT_W'(MAX_FEATURES);

   always_comb begin
      if (fcount_ff == '0) begin
         fc_eff = CNT_W'(1);
      end else if (CNT_W'(fcount_ff) > CNT_W'(MAX_FEATURES)) begin
         fc_eff = CNT_W'(MAX_FEATURES);
      end else begin
         fc_eff = CNT_W'(fcount_ff);
      end
      pos_cl = (CNT_W'(feat_pos_ff) >= fc_eff) ? PW'(fc_eff - CNT_W'(1)) : feat_pos_ff;
      feat_last = (CNT_W'(pos_cl) + CNT_W'(1)) >= fc_eff;
      sc_eff = (scount_ff == '0) ? (SCOUNT_W+1)'(1) : {1'b0, scount_ff};
      sample_last = ({1'b0, sample_pos_ff} + (SCOUNT_W+1)'(1)) >= sc_eff;

      tag_in.first = (pos_cl == '0);
      tag_in.done = feat_last;
      tag_in.last_sample = feat_last && sample_last;

      feat_pos_in = feat_pos_ff;
      sample_pos_in = sample_pos_ff;
      if (accept_feat) begin
         feat_pos_in = feat_last ? '0 : (pos_cl + PW'(1));
         if (feat_last) begin
            sample_pos_in = sample_last ? '0 : (sample_pos_ff + SCOUNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_pos_ff <= '0;
         sample_pos_ff <= '0;
      end else begin
         feat_pos_ff <= feat_pos_in;
         sample_pos_ff <= sample_pos_in;
      end
   end

   assign req_stall = !head_ready;

   lrp_weight_store #(
      .DEPTH(MAX_FEATURES),
      .ADDR_W(PW)
   ) u_store (
      .clock(clock),
      .write_en(accept_weight && slot_ok),
      .write_addr(PW'(req_weight_slot)),
      .write_data(req_value),
      .read_en(accept_feat),
      .read_addr(pos_cl),
      .read_data(weight)
   );

   lrp_mac u_mac (
      .clock(clock),
      .reset(reset),
      .load(accept_feat),
      .value(req_value),
      .tag(tag_in),
      .weight(weight),
      .bias(bias_ff),
      .head_ready(head_ready),
      .down_ready(sig_ready),
      .out_valid(mac_valid),
      .out_last_sample(mac_last_sample),
      .out_sum(mac_sum)
   );

   lrp_sigmoid #(
      .TABLE_BITS(SIGMOID_TABLE_BITS)
   ) u_sigmoid (
      .clock(clock),
      .reset(reset),
      .in_valid(mac_valid),
      .in_last_sample(mac_last_sample),
      .in_sum(mac_sum),
      .in_ready(sig_ready),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_probability(rsp_probability),
      .out_last_sample(rsp_last_sample)
   );

`ifndef NO_ASSERTIONS
   a_feat_advance: assert property (@(posedge clock) disable iff (reset)
      (accept_feat && !feat_last) |=> (feat_pos_ff == $past(pos_cl) + PW'(1)))
      else $error("feature position did not advance");

   a_sample_advance: assert property (@(posedge clock) disable iff (reset)
      (accept_feat && feat_last && !sample_last) |=>
      (sample_pos_ff == $past(sample_pos_ff) + SCOUNT_W'(1)))
      else $error("sample position did not advance");

   a_batch_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept_feat && tag_in.last_sample) |=> (sample_pos_ff == '0 && feat_pos_ff == '0))
      else $error("batch end did not wrap counters");

   a_weight_hold: assert property (@(posedge clock) disable iff (reset)
      accept_weight |=> ($stable(feat_pos_ff) && $stable(sample_pos_ff)))
      else $error("weight transaction moved counters");
`endif

endmodule

// ===== dv/lrp_prediction_checker.sv =====
`timescale 1ns / 1ps

module lrp_prediction_checker #(
   parameter int MAX_FEATURES = lrp_pkg::DEFAULT_MAX_FEATURES,
   parameter int SIGMOID_TABLE_BITS = lrp_pkg::DEFAULT_SIGMOID_TABLE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [lrp_pkg::OP_W-1:0]             req_op,
   input  logic [lrp_pkg::SLOT_W-1:0]           req_weight_slot,
   input  logic signed [lrp_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [lrp_pkg::PROB_W-1:0]           rsp_probability,
   input  logic                                 rsp_last_sample,
   input  logic                                 csr_we,
   input  logic [lrp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lrp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   checked
);
   import lrp_pkg::*;

   localparam int LUT_SIZE = 1 << SIGMOID_TABLE_BITS;
   localparam int LUT_FRAC = SIGMOID_TABLE_BITS - 4;
   localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam longint Z_LIMIT = 64'sd8 <<< FRAC_W;

   typedef struct packed {
      logic [PROB_W-1:0] probability;
      logic              last_sample;
   } prediction_type;

   logic [PROB_W-1:0] logistic_lut [LUT_SIZE];
   int                weight_mem [MAX_FEATURES];
   prediction_type    predicted_q [$];
   longint            running_sum;
   int                feature_pos;
   int                sample_pos;
   int                bias_reg;
   logic [FCOUNT_W-1:0] fcount_reg;
   logic [SCOUNT_W-1:0] scount_reg;
   int                err_count;
   int                compared;

   function automatic logic [PROB_W-1:0] logistic_point(input int idx);
      longint unsigned mag, term, expo, den, num, q;
      int k, n;
      k = idx - LUT_SIZE / 2;
      mag = 64'((k < 0) ? -k : k);
      term = 64'd1 << 32;
      expo = term;
      n = 1;
      while (n < 200 && term != 64'd0) begin
         term = (term * mag) / (64'(n) << LUT_FRAC);
         expo = expo + term;
         n++;
      end
      den = (64'd1 << 32) + expo;
      num = (k >= 0) ? expo : (64'd1 << 32);
      q = (num * 64'd65536 + den / 64'd2) / den;
      return (q > 64'd65535) ? 16'hFFFF : q[PROB_W-1:0];
   endfunction

   initial begin
      for (int i = 0; i < LUT_SIZE; i++) logistic_lut[i] = logistic_point(i);
   end

   task automatic accumulate_feature(input int feature);
      longint product, total, clamped;
      int fc_eff, sc_eff, lut_idx;
      bit ends_batch;
      fc_eff = (fcount_reg == 0) ? 1 : int'(fcount_reg);
      if (fc_eff > MAX_FEATURES) fc_eff = MAX_FEATURES;
      if (feature_pos >= fc_eff) feature_pos = fc_eff - 1;
      product = (longint'(weight_mem[feature_pos]) * longint'(feature)) >>> FRAC_W;
      total = ((feature_pos == 0) ? longint'(bias_reg) : running_sum) + product;
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      running_sum = total;
      if (feature_pos + 1 < fc_eff) begin
         feature_pos++;
      end else begin
         feature_pos = 0;
         clamped = total;
         if (clamped < -Z_LIMIT) clamped = -Z_LIMIT;
         if (clamped > Z_LIMIT - 1) clamped = Z_LIMIT - 1;
         lut_idx = int'((clamped + Z_LIMIT) >>> (Z_SPAN_W - SIGMOID_TABLE_BITS));
         sc_eff = (scount_reg == 0) ? 1 : int'(scount_reg);
         ends_batch = (sample_pos + 1 >= sc_eff);
         sample_pos = ends_batch ? 0 : ((sample_pos + 1) & 16'hFFFF);
         predicted_q.push_back('{logistic_lut[lut_idx], ends_batch});
      end
   endtask

   always @(posedge clock) begin
      prediction_type seen, want;
      if (reset) begin
         predicted_q.delete();
         running_sum = 0;
         feature_pos = 0;
         sample_pos = 0;
         bias_reg = 0;
         fcount_reg = FCOUNT_W'(1);
         scount_reg = SCOUNT_W'(1);
         err_count = 0;
         compared = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BIAS: bias_reg = int'(csr_wdata);
               CSR_FEATURE_COUNT: fcount_reg = csr_wdata[FCOUNT_W-1:0];
               CSR_SAMPLE_COUNT: scount_reg = csr_wdata[SCOUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_WEIGHT) begin
               if (int'(req_weight_slot) < MAX_FEATURES) weight_mem[req_weight_slot] = req_value;
            end else begin
               accumulate_feature(int'(req_value));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_probability, rsp_last_sample};
            if (predicted_q.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("%0t: unexpected prediction prob %h last %b",
                           $realtime, seen.probability, seen.last_sample);
            end else begin
               want = predicted_q.pop_front();
               compared++;
               if (want.probability !== seen.probability
                   || want.last_sample !== seen.last_sample) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("%0t: mismatch: expected prob %h last %b, got prob %h last %b",
                              $realtime, want.probability, want.last_sample,
                              seen.probability, seen.last_sample);
               end
            end
         end
      end
      mismatches <= err_count;
      outstanding <= predicted_q.size();
      checked <= compared;
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import lrp_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int MAXF = DEFAULT_MAX_FEATURES;
   localparam int ITEM_TARGET = 1950;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE = 8;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0] req_op = OP_WEIGHT;
   logic [SLOT_W-1:0] req_weight_slot = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [PROB_W-1:0] rsp_probability;
   logic rsp_last_sample;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BIAS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches, outstanding, checked;
   int cycles = 0;
   int burst_left = 0;
   int txn_count = 0;
   int phase_count = 0;
   int stall_mode = 0;
   int stall_span = 0;
   bit written [MAXF];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   logistic_regression_predict_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_weight_slot(req_weight_slot),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_probability(rsp_probability),
      .rsp_last_sample(rsp_last_sample),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   lrp_prediction_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_weight_slot(req_weight_slot),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_probability(rsp_probability),
      .rsp_last_sample(rsp_last_sample),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatches(mismatches),
      .outstanding(outstanding),
      .checked(checked)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d predictions outstanding", cycles, outstanding);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_span <= $urandom_range(20, 120);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((cycles % 8) < 3);
      endcase
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: pick_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1, 2, 3: pick_value = $urandom;
         default: pick_value = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   task automatic send_txn(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [31:0] val);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_weight_slot <= slot;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      if (op == OP_WEIGHT) written[slot] = 1'b1;
      txn_count++;
   endtask

   // hold off until every prediction is in and the pipeline has settled
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] b, input logic [FCOUNT_W-1:0] fc,
                             input logic [SCOUNT_W-1:0] sc, input bit poke_unused);
      csr_we <= 1'b1;
      csr_index <= CSR_BIAS;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= CSR_FEATURE_COUNT;
      csr_wdata <= 32'(fc);
      @(posedge clock);
      csr_index <= CSR_SAMPLE_COUNT;
      csr_wdata <= 32'(sc);
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= $urandom;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      phase_count++;
   endtask

   initial begin
      int fc, eff, samples;
      logic [31:0] bias_pick;
      logic [SCOUNT_W-1:0] sc;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_txn(OP_WEIGHT, 8'd255, 32'h8000_0000);
      send_txn(OP_WEIGHT, 8'd0, 32'h7FFF_FFFF);
      send_txn(OP_FEATURE, 8'($urandom), 32'h7FFF_FFFF);
      send_txn(OP_FEATURE, 8'($urandom), 32'h8000_0000);
      send_txn(OP_FEATURE, 8'($urandom), 32'h0000_0000);
      drain();

      // positive overflow then pull back: saturation is visible in the result
      set_config(32'h0000_0000, 9'd5, 16'd0, 1'b1);
      for (int s = 0; s < 5; s++)
         send_txn(OP_WEIGHT, 8'(s), (s < 3) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      repeat (5) send_txn(OP_FEATURE, 8'($urandom), 32'h8000_0000);
      drain();

      set_config(32'h8000_0000, 9'd0, 16'd3, 1'b0);
      send_txn(OP_FEATURE, 8'($urandom), 32'h0001_0000);
      send_txn(OP_FEATURE, 8'($urandom), 32'hFFFF_0000);
      drain();

      // leave a sample half done, then shrink the feature count under it
      set_config(32'h0001_0000, 9'd4, 16'hFFFF, 1'b0);
      repeat (2) send_txn(OP_FEATURE, 8'($urandom), 32'h0000_8000);
      drain();
      set_config(32'h7FFF_FFFF, 9'd2, 16'hFFFF, 1'b0);
      send_txn(OP_FEATURE, 8'($urandom), 32'h0002_0000);
      drain();

      while (txn_count < ITEM_TARGET) begin
         if (phase_count == 5) begin
            fc = MAXF;
         end else if (phase_count == 6) begin
            fc = 511;
         end else begin
            case ($urandom_range(0, 19))
               0: fc = 0;
               1: fc = $urandom_range(257, 510);
               2, 3, 4: fc = $urandom_range(9, 32);
               default: fc = $urandom_range(1, 8);
            endcase
         end
         case ($urandom_range(0, 9))
            0: sc = 16'd0;
            1: sc = 16'hFFFF;
            default: sc = 16'($urandom_range(1, 4));
         endcase
         case ($urandom_range(0, 9))
            0: bias_pick = 32'h7FFF_FFFF;
            1: bias_pick = 32'h8000_0000;
            default: bias_pick = pick_value();
         endcase
         set_config(bias_pick, 9'(fc), sc, $urandom_range(0, 7) == 0);
         eff = (fc == 0) ? 1 : ((fc > MAXF) ? MAXF : fc);
         for (int s = 0; s < eff; s++)
            if (!written[s]) send_txn(OP_WEIGHT, 8'(s), pick_value());
         samples = (eff > 32) ? $urandom_range(1, 2) : $urandom_range(2, 12);
         for (int i = 0; i < samples; i++) begin
            for (int f = 0; f < eff; f++) begin
               if ($urandom_range(0, 9) == 0)
                  send_txn(OP_WEIGHT, 8'($urandom_range(0, 255)), pick_value());
               send_txn(OP_FEATURE, 8'($urandom), pick_value());
            end
         end
         // broken tail: up to a full sample of extra features carried into the next configuration
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, eff)) send_txn(OP_FEATURE, 8'($urandom), pick_value());
         drain();
      end

      drain();
      $display("Drove %0d transactions over %0d configuration phases.", txn_count, phase_count);
      $display("Compared %0d predictions against the model.", checked);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
